[design/xrg_pkg.sv]
// Package for the xoshiro range generator: constants and the request and
// response structs of the shared multiply and remainder units.
// No dependencies; xrg_mul, xrg_div and the top level refer to it.
`timescale 1ns / 1ps

package xrg_pkg;

  // SplitMix64 increment, also the value forced into an all-zero state.
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;

  // SplitMix64 finaliser multipliers and shift distances.
  localparam logic [63:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;
  localparam int MIX_SHIFT_A = 30;
  localparam int MIX_SHIFT_B = 27;
  localparam int MIX_SHIFT_C = 31;

  // The multiplier builds the low 64 bits of a 64 x 64 product from three
  // 32 x 32 partial products, one a cycle.
  localparam int MUL_STEPS = 3;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // The remainder unit retires one dividend bit a cycle.
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

[design/xrg_if.sv]
// Handshake interfaces of the xoshiro range generator: request, result and
// seed write channels. Depends on nothing but the port widths below.
`timescale 1ns / 1ps

// Request channel: one item asks for a raw or a bounded draw.
interface xrg_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;

  modport source (output valid, output op, output range_min, output range_max,
                  input ready);
  modport sink (input valid, input op, input range_min, input range_max,
                output ready);
endinterface

// Result channel: one item per request.
interface xrg_rsp_if;
  logic               valid;
  logic               ready;
  logic        [63:0] raw_value;
  logic signed [31:0] range_value;

  modport source (output valid, output raw_value, output range_value,
                  input ready);
  modport sink (input valid, input raw_value, input range_value,
                output ready);
endinterface

// Seed write channel.
interface xrg_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

[design/xrg_mul.sv]
// Shared multiplier: low 64 bits of a 64 x 64 product in three steps
// using one 32 x 32 multiplier. Depends on xrg_pkg.
`timescale 1ns / 1ps

module xrg_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrg_pkg::mul_req_t req_i,
  output xrg_pkg::mul_rsp_t rsp_o
);

  logic [63:0]                 a_q, b_q, acc_q, acc_d;
  logic [xrg_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                        busy_q, done_q;
  logic [31:0]                 mx, my;
  logic [63:0]                 part;
  logic                        last_step;

  // Pick the partial product for this step: lo*lo, then lo*hi, then hi*lo.
  always_comb begin
    mx        = (cnt_q == xrg_pkg::MUL_CNT_W'(2)) ? a_q[63:32] : a_q[31:0];
    my        = (cnt_q == xrg_pkg::MUL_CNT_W'(1)) ? b_q[63:32] : b_q[31:0];
    part      = 64'(mx) * 64'(my);
    acc_d     = (cnt_q == '0) ? acc_q + part : acc_q + {part[31:0], 32'd0};
    last_step = (cnt_q == xrg_pkg::MUL_CNT_W'(xrg_pkg::MUL_STEPS - 1));
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

[design/xrg_div.sv]
// Shared remainder unit: 64-bit dividend modulo a 33-bit divisor, restoring
// and one dividend bit a cycle. Depends on xrg_pkg.
`timescale 1ns / 1ps

module xrg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrg_pkg::div_req_t req_i,
  output xrg_pkg::div_rsp_t rsp_o
);

  logic [63:0]                   dvd_q;
  logic [32:0]                   dsr_q;
  logic [31:0]                   rem_q;
  logic [xrg_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q, done_q;
  logic [32:0]                   trial, diff;
  logic                          fits, last_step;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  // The partial remainder stays below the divisor, so 32 bits hold it.
  always_comb begin
    trial     = {rem_q, dvd_q[63]};
    fits      = (trial >= dsr_q);
    diff      = trial - dsr_q;
    last_step = (cnt_q == xrg_pkg::DIV_CNT_W'(xrg_pkg::DIV_STEPS - 1));
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Dividend shifter and partial remainder.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= fits ? diff[31:0] : trial[31:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

[design/xoshiro_range_generator.sv]
// Raw draw: ST_DRAW1, ST_DRAW2 and ST_DONE follow the accepted request,
// then the result is registered. Bounded draw: two 64-step passes through
// the bit-serial remainder unit, and each rejected draw repeats the draw.
// Empty bounds: ST_RANGE goes straight to ST_DONE. One item at a time.
// After reset and after every seed write the state words are rebuilt,
// during which neither requests nor seed writes are taken.
`timescale 1ns / 1ps

module xoshiro_range_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  xrg_cfg_if.sink    cfg_i,
  xrg_req_if.sink    req_i,
  xrg_rsp_if.source  rsp_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SEED_ADD  = 4'd1;
  localparam logic [3:0] ST_MIX1      = 4'd2;
  localparam logic [3:0] ST_MIX1_WAIT = 4'd3;
  localparam logic [3:0] ST_MIX2      = 4'd4;
  localparam logic [3:0] ST_MIX2_WAIT = 4'd5;
  localparam logic [3:0] ST_SEED_FIX  = 4'd6;
  localparam logic [3:0] ST_RANGE     = 4'd7;
  localparam logic [3:0] ST_THR       = 4'd8;
  localparam logic [3:0] ST_THR_WAIT  = 4'd9;
  localparam logic [3:0] ST_DRAW1     = 4'd10;
  localparam logic [3:0] ST_DRAW2     = 4'd11;
  localparam logic [3:0] ST_CHECK     = 4'd12;
  localparam logic [3:0] ST_MOD_WAIT  = 4'd13;
  localparam logic [3:0] ST_DONE      = 4'd14;

  logic [3:0]         state_q, state_d;
  logic [63:0]        walk_q;
  logic [1:0]         idx_q;
  logic [63:0]        words_q [4];
  logic               op_q;
  logic [31:0]        lo_q, hi_q;
  logic [32:0]        range_q;
  logic [31:0]        thr_q;
  logic [63:0]        m5_q, v_q;
  logic [31:0]        rv_q;
  logic               out_valid_q;
  logic [63:0]        out_raw_q;
  logic [31:0]        out_rv_q;

  xrg_pkg::mul_req_t  mul_req;
  xrg_pkg::mul_rsp_t  mul_rsp;
  xrg_pkg::div_req_t  div_req;
  xrg_pkg::div_rsp_t  div_rsp;

  logic               cfg_acc, req_acc, out_free, rejected, empty_bounds;
  logic [63:0]        mixed_a, mixed_b, mixed_c, rot7, next_draw;
  logic [63:0]        n0, n1, n2, n3;
  logic [32:0]        span;

  // Handshakes: a seed write wins over a request in the same cycle.
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign req_i.ready = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // SplitMix64 mixing around the shared multiplier.
  always_comb begin
    mixed_a = walk_q ^ (walk_q >> xrg_pkg::MIX_SHIFT_A);
    mixed_b = mul_rsp.prod ^ (mul_rsp.prod >> xrg_pkg::MIX_SHIFT_B);
    mixed_c = mul_rsp.prod ^ (mul_rsp.prod >> xrg_pkg::MIX_SHIFT_C);
    mul_req.start = (state_q == ST_MIX1) || (state_q == ST_MIX2);
    mul_req.a     = (state_q == ST_MIX1) ? mixed_a : mixed_b;
    mul_req.b     = (state_q == ST_MIX1) ? xrg_pkg::MIX_MUL_A : xrg_pkg::MIX_MUL_B;
  end

  // xoshiro256** output scrambler and state transition.
  always_comb begin
    rot7      = {m5_q[56:0], m5_q[63:57]};
    next_draw = {rot7[60:0], 3'd0} + rot7;
    n2 = words_q[2] ^ words_q[0];
    n3 = words_q[3] ^ words_q[1];
    n1 = words_q[1] ^ n2;
    n0 = words_q[0] ^ n3;
  end

  // Bounds, rejection test and remainder requests.
  always_comb begin
    empty_bounds = ($signed(hi_q) <= $signed(lo_q));
    span         = {hi_q[31], hi_q} - {lo_q[31], lo_q} + 33'd1;
    rejected     = (v_q < {32'd0, thr_q});
    div_req.start    = (state_q == ST_THR) || ((state_q == ST_CHECK) && !rejected);
    div_req.dividend = (state_q == ST_THR) ? (64'd0 - {31'd0, range_q}) : v_q;
    div_req.divisor  = range_q;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          state_d = ST_SEED_ADD;
        end else if (req_acc) begin
          state_d = req_i.op ? ST_RANGE : ST_DRAW1;
        end
      end
      ST_SEED_ADD:  state_d = ST_MIX1;
      ST_MIX1:      state_d = ST_MIX1_WAIT;
      ST_MIX1_WAIT: if (mul_rsp.done) begin
        state_d = ST_MIX2;
      end
      ST_MIX2:      state_d = ST_MIX2_WAIT;
      ST_MIX2_WAIT: if (mul_rsp.done) begin
        state_d = (idx_q == 2'd3) ? ST_SEED_FIX : ST_SEED_ADD;
      end
      ST_SEED_FIX:  state_d = ST_IDLE;
      ST_RANGE:     state_d = empty_bounds ? ST_DONE : ST_THR;
      ST_THR:       state_d = ST_THR_WAIT;
      ST_THR_WAIT:  if (div_rsp.done) begin
        state_d = ST_DRAW1;
      end
      ST_DRAW1:     state_d = ST_DRAW2;
      ST_DRAW2:     state_d = op_q ? ST_CHECK : ST_DONE;
      ST_CHECK:     state_d = rejected ? ST_DRAW1 : ST_MOD_WAIT;
      ST_MOD_WAIT:  if (div_rsp.done) begin
        state_d = ST_DONE;
      end
      ST_DONE:      if (out_free) begin
        state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Control state; reset starts the expansion of seed zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEED_ADD;
      walk_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        walk_q <= cfg_i.seed;
        idx_q  <= '0;
      end else if (state_q == ST_SEED_ADD) begin
        walk_q <= walk_q + xrg_pkg::GOLDEN_GAMMA;
      end else if ((state_q == ST_MIX2_WAIT) && mul_rsp.done) begin
        idx_q <= idx_q + 2'd1;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Generator words.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_MIX2_WAIT) && mul_rsp.done) begin
      words_q[idx_q] <= mixed_c;
    end else if (state_q == ST_SEED_FIX) begin
      if ((words_q[0] | words_q[1] | words_q[2] | words_q[3]) == 64'd0) begin
        words_q[0] <= xrg_pkg::GOLDEN_GAMMA;
      end
    end else if (state_q == ST_DRAW1) begin
      words_q[0] <= n0;
      words_q[1] <= n1;
      words_q[2] <= n2 ^ {words_q[1][46:0], 17'd0};
      words_q[3] <= {n3[18:0], n3[63:19]};
    end
  end

  // Item payload and working values.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q <= req_i.op;
      lo_q <= req_i.range_min;
      hi_q <= req_i.range_max;
    end
    if (state_q == ST_RANGE) begin
      range_q <= span;
      v_q     <= '0;
      rv_q    <= lo_q;
    end
    if ((state_q == ST_THR_WAIT) && div_rsp.done) begin
      thr_q <= div_rsp.rem;
    end
    if (state_q == ST_DRAW1) begin
      m5_q <= {words_q[1][61:0], 2'd0} + words_q[1];
    end
    if (state_q == ST_DRAW2) begin
      v_q  <= next_draw;
      rv_q <= '0;
    end
    if ((state_q == ST_MOD_WAIT) && div_rsp.done) begin
      rv_q <= lo_q + div_rsp.rem;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_raw_q <= v_q;
      out_rv_q  <= rv_q;
    end
  end

  xrg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  xrg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.raw_value   = out_raw_q;
  assign rsp_o.range_value = $signed(out_rv_q);

endmodule

[design/xrg_checker.sv]
// Port-level checks for the xoshiro range generator, attached by a bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module xrg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic cfg_valid_i,
  input logic cfg_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i
);

  logic req_acc, cfg_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_i;

  // A waiting result item stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result item withdrawn before it was taken");

  // The block works on one request item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while the previous item is in progress");

  // A seed write starts a rebuild that holds off both channels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> !req_ready_i && !cfg_ready_i)
    else $error("channel ready during state rebuild");

  // A seed write and a request item are never taken together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_acc && cfg_acc))
    else $error("seed write and request item taken in the same cycle");

endmodule

bind xoshiro_range_generator xrg_checker u_xrg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready)
);
